// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the undistortion RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/rlu_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants for the radial lens undistortion block.
// No dependencies; used by rlu_iter and radial_lens_undistort.
package rlu_pkg;

    localparam int COORD_W    = 16;
    localparam int COEF_W     = 24;
    localparam int ITERATIONS = 11;
    localparam int F_W        = 54;   // signed Q.32 factor
    localparam int FD_W       = 51;   // positive factor as divisor
    localparam int N_W        = 52;   // dividend |d|<<32 + f/2
    localparam int Q_W        = 16;   // quotient bits
    localparam int CMP_W      = FD_W + Q_W;
    localparam int ITER_LAT   = 6 + 1 + Q_W + 1;
    localparam int LATENCY    = ITERATIONS * ITER_LAT;

    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_K1 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_K2 = 1'b1;

    localparam logic signed [F_W-1:0]     F_ONE     = 54'sd4294967296;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [COORD_W-1:0] distorted_x;
        logic signed [COORD_W-1:0] distorted_y;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] undistorted_x;
        logic signed [COORD_W-1:0] undistorted_y;
        logic                      out_of_range;
    } out_word_t;

    // Point state carried from iteration to iteration.
    typedef struct packed {
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      flag;
        logic                      halt;
    } pt_t;

endpackage

// ----- rtl/rlu_iter.sv -----
`timescale 1ns / 1ps
// One pipelined undistortion iteration: radius, factor, two dividers.
// Depends on rlu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rlu_iter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [rlu_pkg::COEF_W-1:0]    k1,
    input  logic signed [rlu_pkg::COEF_W-1:0]    k2,
    input  logic                                 in_valid,
    input  rlu_pkg::pt_t                         in_pt,
    output logic                                 out_valid,
    output rlu_pkg::pt_t                         out_pt
);

    typedef struct packed {
        rlu_pkg::pt_t                 pt;
        logic                         ovx;
        logic                         ovy;
        logic [rlu_pkg::N_W-1:0]      rem_x;
        logic [rlu_pkg::N_W-1:0]      rem_y;
        logic [rlu_pkg::Q_W-1:0]      q_x;
        logic [rlu_pkg::Q_W-1:0]      q_y;
        logic [rlu_pkg::FD_W-1:0]     fd;
    } dstage_t;

    // front stages
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    rlu_pkg::pt_t p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg, p6_next;
    logic [31:0] sqx1_reg, sqy1_reg, r2_reg;
    logic [63:0] r2sq;
    logic [36:0] r4_reg;
    logic signed [56:0] t1p_reg, t1p4_reg;
    logic signed [44:0] plo_reg;
    logic signed [41:0] phi_reg;
    logic signed [61:0] t2full;
    logic signed [56:0] t1s;
    logic signed [61:0] t2s;
    logic signed [rlu_pkg::F_W-1:0] f_reg, f_next;
    logic [rlu_pkg::FD_W-1:0] fd6_reg;
    logic [rlu_pkg::N_W-1:0]  nx6_reg, ny6_reg, nx_next, ny_next;
    logic [rlu_pkg::Q_W-1:0]  magx, magy;
    logic fpos;
    logic signed [31:0] sqx_s, sqy_s;

    always_comb
    begin
        sqx_s = in_pt.px * in_pt.px;
        sqy_s = in_pt.py * in_pt.py;
    end

    assign r2sq   = r2_reg * r2_reg;
    assign t2full = ($signed({{20{phi_reg[41]}}, phi_reg}) <<< 20)
                  + $signed({{17{plo_reg[44]}}, plo_reg});
    assign t1s    = t1p4_reg >>> 10;
    assign t2s    = t2full >>> 10;
    assign f_next = rlu_pkg::F_ONE + t1s[rlu_pkg::F_W-1:0] + t2s[rlu_pkg::F_W-1:0];

    // prep: factor sign check, dividends
    always_comb
    begin
        fpos    = !f_reg[rlu_pkg::F_W-1] && (f_reg != '0);
        p6_next = p5_reg;
        if (!p5_reg.halt && !fpos)
        begin
            p6_next.halt = 1'b1;
            p6_next.flag = 1'b1;
            p6_next.px   = p5_reg.dx[15] ? rlu_pkg::COORD_MIN :
                           (p5_reg.dx != '0) ? rlu_pkg::COORD_MAX : '0;
            p6_next.py   = p5_reg.dy[15] ? rlu_pkg::COORD_MIN :
                           (p5_reg.dy != '0) ? rlu_pkg::COORD_MAX : '0;
        end
        magx    = p5_reg.dx[15] ? 16'(-p5_reg.dx) : 16'(p5_reg.dx);
        magy    = p5_reg.dy[15] ? 16'(-p5_reg.dy) : 16'(p5_reg.dy);
        nx_next = {4'b0, magx, 32'b0} + {2'b0, f_reg[rlu_pkg::FD_W-1:1]};
        ny_next = {4'b0, magy, 32'b0} + {2'b0, f_reg[rlu_pkg::FD_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= in_pt;
        sqx1_reg <= sqx_s;
        sqy1_reg <= sqy_s;
        p2_reg   <= p1_reg;
        r2_reg   <= sqx1_reg + sqy1_reg;
        p3_reg   <= p2_reg;
        r4_reg   <= r2sq[62:26];
        t1p_reg  <= k1 * $signed({1'b0, r2_reg});
        p4_reg   <= p3_reg;
        t1p4_reg <= t1p_reg;
        plo_reg  <= k2 * $signed({1'b0, r4_reg[19:0]});
        phi_reg  <= k2 * $signed({1'b0, r4_reg[36:20]});
        p5_reg   <= p4_reg;
        f_reg    <= f_next;
        p6_reg   <= p6_next;
        fd6_reg  <= f_reg[rlu_pkg::FD_W-1:0];
        nx6_reg  <= nx_next;
        ny6_reg  <= ny_next;
    end

    // divider: overflow check, then one quotient bit per stage
    dstage_t ds_stage [0:rlu_pkg::Q_W];
    logic    dv_stage [0:rlu_pkg::Q_W];
    logic [rlu_pkg::CMP_W-1:0] fd_top;
    dstage_t ds0_reg, ds0_next;
    logic    dv0_reg;

    assign fd_top = {fd6_reg, {rlu_pkg::Q_W{1'b0}}};

    always_comb
    begin
        ds0_next       = '0;
        ds0_next.pt    = p6_reg;
        ds0_next.fd    = fd6_reg;
        ds0_next.rem_x = nx6_reg;
        ds0_next.rem_y = ny6_reg;
        ds0_next.ovx   = {(rlu_pkg::CMP_W - rlu_pkg::N_W)'(0), nx6_reg} >= fd_top;
        ds0_next.ovy   = {(rlu_pkg::CMP_W - rlu_pkg::N_W)'(0), ny6_reg} >= fd_top;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv0_reg <= 1'b0;
        else
            dv0_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        ds0_reg <= ds0_next;
    end

    assign ds_stage[0] = ds0_reg;
    assign dv_stage[0] = dv0_reg;

    for (genvar i = 1; i <= rlu_pkg::Q_W; i++)
    begin : g_div
        localparam int B = rlu_pkg::Q_W - i;
        dstage_t ds_reg, ds_next;
        logic    dv_reg;
        logic [rlu_pkg::CMP_W-1:0] sh;
        logic gex, gey;

        always_comb
        begin
            sh      = {(rlu_pkg::CMP_W - rlu_pkg::FD_W)'(0), ds_stage[i-1].fd} << B;
            gex     = {(rlu_pkg::CMP_W - rlu_pkg::N_W)'(0), ds_stage[i-1].rem_x} >= sh;
            gey     = {(rlu_pkg::CMP_W - rlu_pkg::N_W)'(0), ds_stage[i-1].rem_y} >= sh;
            ds_next = ds_stage[i-1];
            if (gex)
                ds_next.rem_x = ds_stage[i-1].rem_x - sh[rlu_pkg::N_W-1:0];
            if (gey)
                ds_next.rem_y = ds_stage[i-1].rem_y - sh[rlu_pkg::N_W-1:0];
            ds_next.q_x[B] = gex;
            ds_next.q_y[B] = gey;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg <= 1'b0;
            else
                dv_reg <= dv_stage[i-1];
        end

        always_ff @(posedge clk)
        begin
            ds_reg <= ds_next;
        end

        assign ds_stage[i] = ds_reg;
        assign dv_stage[i] = dv_reg;
    end

    // final: saturate, apply sign
    dstage_t      dl;
    rlu_pkg::pt_t po_next, po_reg;
    logic         vo_reg;
    logic         satx, saty;

    assign dl = ds_stage[rlu_pkg::Q_W];

    always_comb
    begin
        satx = dl.ovx || (dl.pt.dx[15] ? (dl.q_x[15] && (dl.q_x[14:0] != '0)) : dl.q_x[15]);
        saty = dl.ovy || (dl.pt.dy[15] ? (dl.q_y[15] && (dl.q_y[14:0] != '0)) : dl.q_y[15]);
        po_next = dl.pt;
        if (!dl.pt.halt)
        begin
            if (satx)
                po_next.px = dl.pt.dx[15] ? rlu_pkg::COORD_MIN : rlu_pkg::COORD_MAX;
            else
                po_next.px = dl.pt.dx[15] ? $signed(16'(-dl.q_x)) : $signed(dl.q_x);
            if (saty)
                po_next.py = dl.pt.dy[15] ? rlu_pkg::COORD_MIN : rlu_pkg::COORD_MAX;
            else
                po_next.py = dl.pt.dy[15] ? $signed(16'(-dl.q_y)) : $signed(dl.q_y);
            po_next.flag = dl.pt.flag || satx || saty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else
            vo_reg <= dv_stage[rlu_pkg::Q_W];
    end

    always_ff @(posedge clk)
    begin
        po_reg <= po_next;
    end

    assign out_valid = vo_reg;
    assign out_pt    = po_reg;

    `ASSERT_IMPLIES(a_lat, clk, rst_n, out_valid, $past(in_valid, rlu_pkg::ITER_LAT))
    `ASSERT_IMPLIES(a_halt_flag, clk, rst_n, out_valid && out_pt.halt, out_pt.flag)
    `ASSERT_IMPLIES(a_halt_hold, clk, rst_n, out_valid && $past(in_valid && in_pt.halt, rlu_pkg::ITER_LAT), out_pt.px == $past(in_pt.px, rlu_pkg::ITER_LAT))

endmodule

// ----- rtl/radial_lens_undistort.sv -----
`timescale 1ns / 1ps
// Top level of the radial lens undistortion block: k1/k2 registers and
// the chain of iteration pipelines. Depends on rlu_pkg, rlu_iter, macros.
//
// Use:
//   A distorted point (Q3.13 x/y) is taken at each rising edge with start
//   high and busy low; busy is always low, so a word may enter every cycle.
//   The undistorted word appears on result for one cycle with done high,
//   after it has passed the whole chain of iterations, in order.
//   Each of the 11 iterations is a 24-stage pipeline: 6 stages for r2, r4,
//   k1/k2 products and the factor, then a 17-stage restoring divider
//   (overflow check plus one quotient bit per stage, x and y lanes side by
//   side) and a saturation stage. Throughput is one word per clock.
//   k1/k2 are written through cfg_we/cfg_index/cfg_data and should only be
//   changed while the pipeline is empty.
//   Reset clears the coefficients to zero and empties the pipeline; words in
//   flight are dropped. The receiver cannot stall: a result is presented
//   for a single cycle and must be captured then.
`include "assert_macros.svh"

module radial_lens_undistort (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  rlu_pkg::in_word_t                 point,
    output logic                              done,
    output rlu_pkg::out_word_t                result,
    input  logic                              cfg_we,
    input  logic [rlu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rlu_pkg::COEF_W-1:0]        cfg_data
);

    logic signed [rlu_pkg::COEF_W-1:0] k1_reg, k2_reg;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg <= '0;
            k2_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rlu_pkg::CFG_K1: k1_reg <= $signed(cfg_data);
                rlu_pkg::CFG_K2: k2_reg <= $signed(cfg_data);
                default:         ;
            endcase
        end
    end

    // iteration chain; entry estimate is the distorted point itself
    logic         iv [0:rlu_pkg::ITERATIONS];
    rlu_pkg::pt_t ip [0:rlu_pkg::ITERATIONS];

    assign busy  = 1'b0;
    assign iv[0] = start;
    assign ip[0] = '{dx:   point.distorted_x,
                     dy:   point.distorted_y,
                     px:   point.distorted_x,
                     py:   point.distorted_y,
                     flag: 1'b0,
                     halt: 1'b0};

    for (genvar i = 0; i < rlu_pkg::ITERATIONS; i++)
    begin : g_iter
        rlu_iter u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .k1        (k1_reg),
            .k2        (k2_reg),
            .in_valid  (iv[i]),
            .in_pt     (ip[i]),
            .out_valid (iv[i+1]),
            .out_pt    (ip[i+1])
        );
    end

    // last iteration's output stage is the result register
    assign done                 = iv[rlu_pkg::ITERATIONS];
    assign result.undistorted_x = ip[rlu_pkg::ITERATIONS].px;
    assign result.undistorted_y = ip[rlu_pkg::ITERATIONS].py;
    assign result.out_of_range  = ip[rlu_pkg::ITERATIONS].flag;

    `ASSERT_IMPLIES(a_done_lat, clk, rst_n, done, $past(start, rlu_pkg::LATENCY))
    `ASSERT_NEXT(a_k1_wr, clk, rst_n, cfg_we && cfg_index == rlu_pkg::CFG_K1, k1_reg == $signed($past(cfg_data)))
    `ASSERT_NEXT(a_k2_wr, clk, rst_n, cfg_we && cfg_index == rlu_pkg::CFG_K2, k2_reg == $signed($past(cfg_data)))

endmodule

// ----- dv/tb_radial_lens_undistort.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for radial_lens_undistort: drives distorted points
// and k1/k2 settings, predicts each undistorted word. Depends on rlu_pkg and the RTL.
module tb_radial_lens_undistort;

    // Scoreboard: holds the coefficients and the expected undistorted words.
    class undistort_scoreboard;
        longint             k1;
        longint             k2;
        rlu_pkg::out_word_t expected_words[$];
        int                 errors;

        function new();
            k1 = 0;
            k2 = 0;
            errors = 0;
        endfunction

        function void set_coef(logic [rlu_pkg::CFG_IDX_W-1:0] idx,
                               logic [rlu_pkg::COEF_W-1:0] val);
            longint v;
            v = longint'($signed(val));
            if (idx == rlu_pkg::CFG_K1)
                k1 = v;
            else if (idx == rlu_pkg::CFG_K2)
                k2 = v;
        endfunction

        // Rounded |d|/f with the sign of d, clamped to Q3.13.
        function longint scaled_coord(longint d, longint f, inout bit sat);
            longint unsigned mag;
            longint unsigned q;
            mag = (d < 0) ? longint'(-d) : longint'(d);
            q = ((mag << 32) + (longint'(f) >> 1)) / longint'(f);
            if (d < 0)
            begin
                if (q > 32768)
                begin
                    sat = 1'b1;
                    return -32768;
                end
                return -longint'(q);
            end
            if (q > 32767)
            begin
                sat = 1'b1;
                return 32767;
            end
            return longint'(q);
        endfunction

        function longint rail(longint d);
            return (d > 0) ? 32767 : ((d < 0) ? -32768 : 0);
        endfunction

        function void note_point(rlu_pkg::in_word_t w);
            longint dx, dy, px, py, t1, t2, f;
            longint unsigned r2, r4;
            bit sat;
            rlu_pkg::out_word_t o;
            dx = longint'(w.distorted_x);
            dy = longint'(w.distorted_y);
            px = dx;
            py = dy;
            sat = 1'b0;
            for (int it = 0; it < rlu_pkg::ITERATIONS; it++)
            begin
                r2 = longint'(px * px) + longint'(py * py);
                r4 = (r2 * r2) >> 26;
                t1 = (k1 * longint'(r2)) >>> 10;
                t2 = (k2 * longint'(r4)) >>> 10;
                f  = (longint'(1) << 32) + t1 + t2;
                if (f <= 0)
                begin
                    px = rail(dx);
                    py = rail(dy);
                    sat = 1'b1;
                    break;
                end
                px = scaled_coord(dx, f, sat);
                py = scaled_coord(dy, f, sat);
            end
            o.undistorted_x = px[15:0];
            o.undistorted_y = py[15:0];
            o.out_of_range  = sat;
            expected_words.push_back(o);
        endfunction

        function void check_word(rlu_pkg::out_word_t got);
            rlu_pkg::out_word_t e;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            if (got.undistorted_x !== e.undistorted_x)
            begin
                $display("%0t: undistorted_x expected %0d actual %0d",
                         $time, e.undistorted_x, got.undistorted_x);
                errors++;
            end
            if (got.undistorted_y !== e.undistorted_y)
            begin
                $display("%0t: undistorted_y expected %0d actual %0d",
                         $time, e.undistorted_y, got.undistorted_y);
                errors++;
            end
            if (got.out_of_range !== e.out_of_range)
            begin
                $display("%0t: out_of_range expected %0b actual %0b",
                         $time, e.out_of_range, got.out_of_range);
                errors++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    rlu_pkg::in_word_t             point;
    logic                          done;
    rlu_pkg::out_word_t            result;
    logic                          cfg_we;
    logic [rlu_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rlu_pkg::COEF_W-1:0]    cfg_data;

    undistort_scoreboard sb;
    int                  cycles;
    bit                  no_gaps;

    localparam int CYCLE_LIMIT = 200000;

    radial_lens_undistort dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Results cannot be held off: take each one in the cycle it is shown.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_word(result);
    end

    // One point; start stays high if the next call follows without a gap.
    task automatic send_point(logic signed [15:0] x, logic signed [15:0] y);
        @(negedge clk);
        start <= 1'b1;
        point <= '{distorted_x: x, distorted_y: y};
        do
            @(posedge clk);
        while (busy);
        sb.note_point('{distorted_x: x, distorted_y: y});
        // occasional gap
        if (!no_gaps && $urandom_range(99) < 6)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(3)) @(negedge clk);
        end
    endtask

    // Drain the pipe, then load both coefficients.
    task automatic load_coefs(logic [rlu_pkg::COEF_W-1:0] c1,
                              logic [rlu_pkg::COEF_W-1:0] c2);
        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= rlu_pkg::CFG_K1;
        cfg_data  <= c1;
        @(posedge clk);
        sb.set_coef(rlu_pkg::CFG_K1, c1);
        @(negedge clk);
        cfg_index <= rlu_pkg::CFG_K2;
        cfg_data  <= c2;
        @(posedge clk);
        sb.set_coef(rlu_pkg::CFG_K2, c2);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_points(int n, int span);
        logic signed [15:0] x, y;
        for (int i = 0; i < n; i++)
        begin
            if (span == 0)
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            else
            begin
                x = 16'($urandom_range(2 * span) - span);
                y = 16'($urandom_range(2 * span) - span);
            end
            send_point(x, y);
        end
    endtask

    initial
    begin
        logic signed [15:0] corner[5];
        sb        = new();
        cycles    = 0;
        no_gaps   = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        point     = '0;
        cfg_we    = 1'b0;
        cfg_index = rlu_pkg::CFG_K1;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: corners with identity lens, then barrel lens that
        // drives the factor negative, then pincushion, zero factor, mild barrel.
        corner = '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1, -16'sd1};
        foreach (corner[i])
            send_point(corner[i], corner[(i + 2) % 5]);
        load_coefs(24'h800000, 24'h800000);           // both at minimum
        send_point(16'sh7FFF, 16'sh8000);
        send_point(16'sd0, 16'sd0);
        send_point(16'sd0, 16'sd1);
        send_point(16'sh1000, -16'sh1000);
        load_coefs(24'h7FFFFF, 24'h7FFFFF);           // both at maximum
        send_point(16'sh7FFF, 16'sh7FFF);
        send_point(16'sh8000, 16'sd0);
        send_point(16'sd1, -16'sd1);
        load_coefs(24'hFF0000, 24'h000000);           // k1 = -1: factor hits zero
        send_point(16'sh2000, 16'sd0);
        send_point(16'sh4000, 16'sh4000);
        send_point(16'sh0800, 16'sh0800);
        load_coefs(24'hFFB334, 24'h001999);           // mild barrel
        send_point(16'sh7FFF, 16'sh8000);
        send_point(16'sh1800, -16'sh0C00);

        // Random phases, mostly inside the unit circle where lenses are used.
        load_coefs(24'hFFB334, 24'h001999);
        random_points(80, 8192);
        random_points(20, 0);
        no_gaps = 1'b1;                               // back-to-back stretch
        load_coefs(24'h00570A, 24'hFFF000);           // pincushion
        random_points(100, 12000);
        no_gaps = 1'b0;
        load_coefs(24'($urandom), 24'($urandom));
        random_points(60, 8192);
        random_points(40, 0);
        load_coefs(24'($urandom_range(24'h03FFFF)), 24'($urandom_range(24'h00FFFF)));
        random_points(100, 16384);
        load_coefs(24'(24'hFFC000 | $urandom_range(24'h3FFF)), 24'($urandom));
        random_points(100, 8192);

        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (rlu_pkg::LATENCY + 20) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/rlu_pkg.sv
rtl/rlu_iter.sv
rtl/radial_lens_undistort.sv
dv/tb_radial_lens_undistort.sv
